@@ rtl/hem_pkg.sv @@
// Shared types and constants for the histogram equalization map block.
package hem_pkg;

	localparam int CNT_W = 24;
	localparam int WGT_W = 8;
	localparam int TERM_W = CNT_W + WGT_W;
	localparam int LVL_W = 12;
	localparam int OCC_W = 13;
	localparam int BINS_W = 13;
	localparam int IDX_W = 12;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_BINS    = 1'b0,
		REG_WEIGHTS = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_SUM_DRAIN,
		ST_CHECK,
		ST_IDENT,
		ST_RD,
		ST_TERM,
		ST_ACC,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV,
		ST_WR,
		ST_FIN,
		ST_READ
	} state_t;

endpackage

@@ rtl/histogram_equalization_map.sv @@
// Top level: histogram bin store, cumulative map builder and map read-out.
//
// Channel   Dir  Words
// s_axis    in   command in tuser; bin_index, bin_count, bin_weight in tdata
// m_axis    out  map_value, occupied_levels (finish and read only)
// cfg       in   register index and write data; always ready
//
// Load and no-op words are taken in ST_IDLE; a read moves to ST_READ and holds
// there until the output register is free.
// Finish sweeps the bin memory twice: a pipelined sum pass and a per-bin
// pass through read, weighting, accumulate, multiply and the bit-serial
// divider. With a zero total the second pass writes the identity map
// instead. No word is accepted during finish.
// Reset clears control and config registers only; datapath registers and
// memories are undefined until written.
module histogram_equalization_map #(
	parameter int MAX_BINS = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [47:0]                 s_axis_tdata,  // bin_index, bin_count, bin_weight, pad
	input  logic [1:0]                  s_axis_tuser,  // command
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,  // map_value, occupied_levels, pad
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  hem_pkg::reg_idx_t           cfg_index,
	input  logic [hem_pkg::BINS_W-1:0]  cfg_data
);
	import hem_pkg::*;

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CW = TERM_W + AW;  // cumulative sum
	localparam int PW = CW + AW;      // cumulative sum times (n-1)

	// input word fields
	logic [IDX_W-1:0] in_idx;
	logic [CNT_W-1:0] in_cnt;
	logic [WGT_W-1:0] in_wgt;
	cmd_t             in_cmd;
	logic             in_acc;
	logic             in_range;

	assign in_idx   = s_axis_tdata[11:0];
	assign in_cnt   = s_axis_tdata[35:12];
	assign in_wgt   = s_axis_tdata[43:36];
	assign in_cmd   = cmd_t'(s_axis_tuser);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign in_range = ({1'b0, in_idx} < (IDX_W + 1)'(MAX_BINS));

	// config registers
	logic [BINS_W-1:0] bins_q;
	logic              weights_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q    <= BINS_W'(256);
			weights_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BINS:    bins_q    <= cfg_data;
				REG_WEIGHTS: weights_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// effective last bin index, clamped to [1, MAX_BINS-1]
	logic [AW-1:0] nm1_in;
	always_comb begin
		priority if (bins_q < BINS_W'(2)) begin
			nm1_in = AW'(1);
		end else if (bins_q > BINS_W'(MAX_BINS)) begin
			nm1_in = AW'(MAX_BINS - 1);
		end else begin
			nm1_in = AW'(bins_q - 1'b1);
		end
	end

	// FSM and datapath registers
	state_t           state_q, state_d;
	logic [AW-1:0]    nm1_q;
	logic [AW-1:0]    i_q;
	logic             v_s1, v_s2;
	logic [TERM_W-1:0] term_s2;
	logic             nz_s2;
	logic [CW-1:0]    acc_q;
	logic [CW-1:0]    total_q;
	logic [CW-1:0]    cf_q;
	logic [PW-1:0]    prod_q;
	logic [OCC_W-1:0] hits_q;
	logic [OCC_W-1:0] occ_q;
	logic [LVL_W-1:0] last_lvl_q;
	logic             any_hit_q;
	logic             oob_q;
	logic             last_bin;

	// outputs of the control decode
	logic             bin_we;
	logic             bin_re;
	logic [AW-1:0]    bin_raddr;
	logic             map_we;
	logic [AW-1:0]    map_waddr;
	logic [LVL_W-1:0] map_wdata;
	logic             map_re;
	logic             out_load;
	logic             out_free;
	logic             div_start;
	logic             div_done;
	logic [LVL_W-1:0] div_quo;

	assign last_bin = (i_q == nm1_q);
	assign out_free = !m_axis_tvalid || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_cmd == CMD_FINISH) begin
					state_d = ST_SUM;
				end else if (in_acc && in_cmd == CMD_READ) begin
					state_d = ST_READ;
				end
			end
			ST_SUM:       if (last_bin) state_d = ST_SUM_DRAIN;
			ST_SUM_DRAIN: if (!v_s1 && !v_s2) state_d = ST_CHECK;
			ST_CHECK:     state_d = (acc_q == '0) ? ST_IDENT : ST_RD;
			ST_IDENT:     if (last_bin) state_d = ST_FIN;
			ST_RD:        state_d = ST_TERM;
			ST_TERM:      state_d = ST_ACC;
			ST_ACC:       state_d = ST_MUL;
			ST_MUL:       state_d = ST_DIV_GO;
			ST_DIV_GO:    state_d = ST_DIV;
			ST_DIV:       if (div_done) state_d = ST_WR;
			ST_WR:        state_d = last_bin ? ST_FIN : ST_RD;
			ST_FIN:       if (out_free) state_d = ST_IDLE;
			ST_READ:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		bin_we        = (state_q == ST_IDLE) && in_acc && in_cmd == CMD_LOAD && in_range;
		bin_re        = (state_q == ST_SUM) || (state_q == ST_RD);
		bin_raddr     = i_q;
		map_re        = (state_q == ST_IDLE) && in_acc && in_cmd == CMD_READ;
		map_we        = (state_q == ST_IDENT) || (state_q == ST_WR);
		map_waddr     = i_q;
		map_wdata     = (state_q == ST_WR) ? div_quo : LVL_W'(i_q);
		div_start     = (state_q == ST_DIV_GO);
		out_load      = ((state_q == ST_FIN) || (state_q == ST_READ)) && out_free;
	end

	// bin memory: {weight, count}
	logic [TERM_W-1:0] bin_mem [MAX_BINS];
	logic [TERM_W-1:0] bin_rdata;

	always_ff @(posedge clk) begin
		if (bin_we) begin
			bin_mem[in_idx[AW-1:0]] <= {in_wgt, in_cnt};
		end
		if (bin_re) begin
			bin_rdata <= bin_mem[bin_raddr];
		end
	end

	// map memory
	logic [LVL_W-1:0] map_mem [MAX_BINS];
	logic [LVL_W-1:0] map_rdata;

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		if (map_re) begin
			map_rdata <= map_mem[in_idx[AW-1:0]];
		end
	end

	// weighted term of the word just read
	logic [WGT_W-1:0] wgt_eff;
	assign wgt_eff = weights_q ? bin_rdata[TERM_W-1:CNT_W] : WGT_W'(1);

	always_ff @(posedge clk) begin
		term_s2 <= TERM_W'(bin_rdata[CNT_W-1:0]) * TERM_W'(wgt_eff);
		nz_s2   <= (bin_rdata[CNT_W-1:0] != '0);
	end

	hem_div #(
		.NW(PW),
		.DW(CW),
		.QW(LVL_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (prod_q),
		.den   (total_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			i_q           <= '0;
			nm1_q         <= '0;
			occ_q         <= '0;
			hits_q        <= '0;
			any_hit_q     <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_SUM);
			v_s2    <= v_s1;
			if (state_q == ST_IDLE && in_acc && in_cmd == CMD_FINISH) begin
				nm1_q <= nm1_in;
				i_q   <= '0;
			end else if (state_q == ST_SUM || state_q == ST_IDENT || state_q == ST_WR) begin
				i_q <= last_bin ? '0 : i_q + 1'b1;
			end
			if (state_q == ST_CHECK) begin
				hits_q    <= '0;
				any_hit_q <= 1'b0;
			end else if (state_q == ST_WR && nz_s2 &&
					(!any_hit_q || div_quo != last_lvl_q)) begin
				hits_q    <= hits_q + 1'b1;
				any_hit_q <= 1'b1;
			end
			if (state_q == ST_FIN && out_free) begin
				occ_q <= hits_q;
			end
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			acc_q <= '0;
			oob_q <= !in_range;
		end else if (v_s2) begin
			acc_q <= acc_q + CW'(term_s2);
		end
		if (state_q == ST_CHECK) begin
			total_q <= acc_q;
			cf_q    <= '0;
		end else if (state_q == ST_ACC) begin
			cf_q <= cf_q + CW'(term_s2);
		end
		if (state_q == ST_MUL) begin
			prod_q <= PW'(cf_q) * PW'(nm1_q);
		end
		if (state_q == ST_WR && nz_s2) begin
			last_lvl_q <= div_quo;
		end
		if (out_load) begin
			if (state_q == ST_FIN) begin
				m_axis_tdata <= {7'd0, hits_q, LVL_W'(0)};
			end else begin
				m_axis_tdata <= {7'd0, occ_q, oob_q ? LVL_W'(0) : map_rdata};
			end
		end
	end

endmodule

@@ rtl/hem_div.sv @@
// Restoring divider, one quotient bit per cycle.
module hem_div #(
	parameter int NW = 56,
	parameter int DW = 44,
	parameter int QW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo
);
	import hem_pkg::*;

	localparam int WW = (NW > DW + QW) ? NW : DW + QW;
	localparam int SW = (QW > 1) ? $clog2(QW) : 1;

	logic [WW-1:0] rem_q;
	logic [WW-1:0] dsh_q;
	logic [QW-1:0] quo_q;
	logic [SW-1:0] step_q;
	logic          run_q;
	logic          done_q;
	logic          take;

	assign take = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && run_q && (step_q == '0);
			if (start) begin
				run_q  <= 1'b1;
				step_q <= SW'(QW - 1);
			end else if (run_q) begin
				if (step_q == '0) begin
					run_q <= 1'b0;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= WW'(num);
			dsh_q <= WW'(den) << (QW - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (take) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ dv/histogram_equalization_map_test.sv @@
// Testbench for the histogram equalization map block: directed and random traffic checked against a predictor.
module histogram_equalization_map_test;
	import hem_pkg::*;

	localparam int NBINS = 4096;

	// Scoreboard: mirrors the bin stores and map, queues expected result words.
	class hem_scoreboard;
		logic [23:0] counts [NBINS];
		logic [7:0] weights [NBINS];
		logic [11:0] levels [NBINS];
		logic [12:0] occupied;
		logic [12:0] bins_reg;
		bit weighted;
		logic [24:0] pending [$];
		int errors;

		function void reset_state();
			bins_reg = 13'd256;
			weighted = 0;
			occupied = '0;
			pending.delete();
			errors = 0;
		endfunction

		// cumulative equalization over the active bins
		function void build_map();
			int unsigned n;
			longint unsigned acc, total, lvl;
			longint unsigned cum [NBINS];
			bit hit [NBINS];
			int unsigned nhits;
			n = bins_reg < 2 ? 2 : (bins_reg > NBINS ? NBINS : bins_reg);
			acc = 0;
			nhits = 0;
			for (int i = 0; i < n; i++) begin
				acc += weighted ? longint'(counts[i]) * weights[i] : longint'(counts[i]);
				cum[i] = acc;
				hit[i] = 0;
			end
			total = acc;
			if (total == 0) begin
				for (int i = 0; i < n; i++)
					levels[i] = i[11:0];
				occupied = '0;
				return;
			end
			for (int i = 0; i < n; i++) begin
				lvl = cum[i] * (n - 1) / total;
				if (lvl > 64'(n - 1))
					lvl = 64'(n - 1);
				levels[i] = lvl[11:0];
				if (counts[i] != 0 && !hit[lvl]) begin
					hit[lvl] = 1;
					nhits++;
				end
			end
			occupied = nhits[12:0];
		endfunction

		function void note_word(cmd_t cmd, logic [11:0] idx, logic [23:0] cnt, logic [7:0] wgt);
			case (cmd)
				CMD_LOAD: begin
					counts[idx] = cnt;
					weights[idx] = wgt;
				end
				CMD_FINISH: begin
					build_map();
					pending.push_back({occupied, 12'd0});
				end
				CMD_READ: pending.push_back({occupied, levels[idx]});
				default: ;
			endcase
		endfunction

		function void check_word(logic [31:0] data);
			logic [24:0] want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, data);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data[11:0] !== want[11:0]) begin
				$display("%0t: map_value expected %0d actual %0d", $time, want[11:0], data[11:0]);
				errors++;
			end
			if (data[24:12] !== want[24:12]) begin
				$display("%0t: occupied_levels expected %0d actual %0d", $time, want[24:12],
					data[24:12]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tready;
	logic [47:0] s_axis_tdata = '0;  // bin_index, bin_count, bin_weight, pad
	logic [1:0] s_axis_tuser = CMD_NOP;  // command
	logic m_axis_tvalid, m_axis_tready = 0;
	logic [31:0] m_axis_tdata;  // map_value, occupied_levels, pad
	logic cfg_valid = 0, cfg_ready;
	reg_idx_t cfg_index = REG_BINS;
	logic [BINS_W-1:0] cfg_data = '0;

	hem_scoreboard sb = new();
	bit calm = 0;  // no idling in the final stretch
	bit written [NBINS];  // map entries computed so far
	int n_act = 256;

	histogram_equalization_map uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Result side: random stall bursts unless in the calm stretch.
	initial begin
		int stall;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 14);
				m_axis_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata);

	// Drive one word and hold it until accepted; optional idle burst first.
	task automatic send_word(cmd_t cmd, logic [11:0] idx, logic [23:0] cnt, logic [7:0] wgt);
		if (!calm && $urandom_range(0, 6) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'd0, wgt, cnt, idx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(cmd, idx, cnt, wgt);
		if (cmd == CMD_FINISH)
			for (int i = 0; i < n_act; i++)
				written[i] = 1;
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 0;
		@(posedge clk);
	endtask

	// Wait until nothing is outstanding, plus a margin.
	task automatic drain();
		stop_sending();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Registers change only with the block idle and no word outstanding.
	task automatic write_reg(reg_idx_t idx, logic [BINS_W-1:0] val);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == REG_BINS) begin
			sb.bins_reg = val;
			n_act = val < 2 ? 2 : (val > NBINS ? NBINS : val);
		end else
			sb.weighted = val[0];
		@(posedge clk);
	endtask

	// Load every active bin, with random or extreme content.
	task automatic load_all(int mode);
		logic [23:0] c;
		for (int i = 0; i < n_act; i++) begin
			case (mode)
				0: c = 24'd0;
				1: c = 24'hFFFFFF;
				2: c = $urandom_range(0, 3) == 0 ? 24'd0 : 24'($urandom_range(0, 24'hFFFFFF));
				default: c = $urandom_range(0, 3) == 0 ? 24'd0 : 24'($urandom_range(0, 50));
			endcase
			send_word(CMD_LOAD, i[11:0], c, mode == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic random_reads(int k);
		logic [11:0] idx;
		for (int j = 0; j < k; j++) begin
			idx = 12'($urandom_range(0, NBINS - 1));
			if (!written[idx])
				idx = 12'($urandom_range(0, n_act - 1));
			send_word(CMD_READ, idx, 24'($urandom), 8'($urandom));
		end
	endtask

	task automatic round(int mode, int reads);
		load_all(mode);
		if ($urandom_range(0, 1))
			send_word(CMD_NOP, 12'($urandom), 24'($urandom), 8'($urandom));
		send_word(CMD_FINISH, 12'($urandom), 24'($urandom), 8'($urandom));
		random_reads(reads);
	endtask

	initial begin
		sb.reset_state();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: smallest size, zero total, full-scale counts, out-of-range sizes.
		write_reg(REG_BINS, 13'd0);
		write_reg(REG_WEIGHTS, 13'd0);
		round(0, 2);
		round(1, 2);
		drain();
		write_reg(REG_WEIGHTS, 13'd1);
		round(1, 2);
		send_word(CMD_LOAD, 12'd0, 24'd5, 8'd0);
		send_word(CMD_LOAD, 12'd1, 24'd0, 8'd200);
		send_word(CMD_FINISH, 12'hFFF, 24'hFFFFFF, 8'hFF);
		random_reads(2);
		drain();

		// Random phases: mostly small sizes.
		for (int p = 0; p < 33; p++) begin
			write_reg(REG_BINS, 13'($urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
				: $urandom_range(2, 12)));
			write_reg(REG_WEIGHTS, 13'($urandom_range(0, 1)));
			if (n_act > 64)
				write_reg(REG_BINS, 13'($urandom_range(2, 40)));
			round($urandom_range(2, 3), $urandom_range(3, 10));
			if (p % 10 == 3)
				drain();
		end
		drain();
		calm = 1;
		write_reg(REG_BINS, 13'd256);
		write_reg(REG_WEIGHTS, 13'd0);
		round(2, 20);
		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#100000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
